/* design/bst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream tokenizer package
// Shared constants, token codes, result type and character class helpers.
// ----------------------------------------------------------------------------
package bst_pkg;

	localparam int POS_WIDTH  = 16;
	localparam int SPAN_WIDTH = 16;
	localparam int RES_DEPTH  = 4;
	localparam int RES_PTR_W  = $clog2(RES_DEPTH);
	localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

	localparam logic [2:0] KW_LEN  = 3'd4;
	localparam logic [2:0] KW_MISS = 3'd7;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		TK_NAT     = 3'd0,
		TK_KW_SHOW = 3'd1,
		TK_END     = 3'd2,
		TK_UNKNOWN = 3'd3,
		TK_ILLEGAL = 3'd4,
		TK_LONG    = 3'd5
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t              kind;
		logic [SPAN_WIDTH-1:0] span_start;
		logic [SPAN_WIDTH-1:0] span_end;
		logic                  last;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} scan_res_t;

	function automatic res_t make_res(tok_kind_t k, logic [SPAN_WIDTH-1:0] s,
			logic [SPAN_WIDTH-1:0] e);
		res_t r;
		r.kind       = k;
		r.span_start = s;
		r.span_end   = e;
		r.last       = 1'b0;
		return r;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_ident_start(logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
			|| (c == 8'h5F);
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
	endfunction

	function automatic logic [7:0] kw_letter(logic [1:0] idx);
		logic [7:0] l;
		case (idx)
			2'd0: l = 8'h73;
			2'd1: l = 8'h68;
			2'd2: l = 8'h6F;
			2'd3: l = 8'h77;
			default: l = 8'h00;
		endcase
		return l;
	endfunction

	function automatic logic [2:0] kw_advance(logic [2:0] prog, logic [7:0] c);
		if ((prog < KW_LEN) && (c == kw_letter(prog[1:0])))
			return prog + 3'd1;
		return KW_MISS;
	endfunction

endpackage

/* design/bst_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source byte channel
// Valid/ready channel carrying one source byte or an end-of-source beat.
// ----------------------------------------------------------------------------
interface bst_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] ch;

	modport source(output valid, output kind, output ch, input ready);
	modport sink(input valid, input kind, input ch, output ready);
endinterface

/* design/bst_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token channel
// Valid/ready channel carrying one token or error with its byte span.
// ----------------------------------------------------------------------------
interface bst_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [15:0] span_start;
	logic [15:0] span_end;
	logic        last_of_item;

	modport source(output valid, output token_kind, output span_start,
		output span_end, output last_of_item, input ready);
	modport sink(input valid, input token_kind, input span_start,
		input span_end, input last_of_item, output ready);
endinterface

/* design/bst_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Lexer state and the single-pass scan of one beat into up to two results.
// ----------------------------------------------------------------------------
module bst_scan #(
	parameter int POS_WIDTH = bst_pkg::POS_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                kind,
	input  logic [7:0]          ch,
	output bst_pkg::scan_res_t  scan
);

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_NUM     = 3'd1,
		M_IDENT   = 3'd2,
		M_SLASH   = 3'd3,
		M_COMMENT = 3'd4,
		M_ERROR   = 3'd5
	} mode_t;

	localparam int SW = bst_pkg::SPAN_WIDTH;
	localparam logic [POS_WIDTH-1:0] POS_ONE = {{(POS_WIDTH-1){1'b0}}, 1'b1};

	mode_t                 mode_q, mode_d;
	logic [POS_WIDTH-1:0]  pos_q, pos_d;
	logic [POS_WIDTH-1:0]  start_q, start_d;
	logic [2:0]            kw_q, kw_d;

	logic [POS_WIDTH-1:0]  pos_inc, start_inc;
	logic [POS_WIDTH+SW-1:0] ext_p, ext_pi, ext_s, ext_si;
	logic [SW-1:0]         p16, pi16, s16, si16;

	logic                  idle_emit;
	bst_pkg::res_t         idle_res;
	mode_t                 idle_mode;
	logic [POS_WIDTH-1:0]  idle_start;
	logic [2:0]            idle_kw;

	bst_pkg::res_t         r0, r1;
	logic [1:0]            cnt;

	assign pos_inc   = pos_q + POS_ONE;
	assign start_inc = start_q + POS_ONE;
	assign ext_p     = {{SW{1'b0}}, pos_q};
	assign ext_pi    = {{SW{1'b0}}, pos_inc};
	assign ext_s     = {{SW{1'b0}}, start_q};
	assign ext_si    = {{SW{1'b0}}, start_inc};
	assign p16       = ext_p[SW-1:0];
	assign pi16      = ext_pi[SW-1:0];
	assign s16       = ext_s[SW-1:0];
	assign si16      = ext_si[SW-1:0];

	// scan of a byte from the idle mode
	always_comb begin
		idle_emit  = 1'b0;
		idle_res   = bst_pkg::make_res(bst_pkg::TK_ILLEGAL, p16, pi16);
		idle_mode  = M_IDLE;
		idle_start = start_q;
		idle_kw    = kw_q;
		if (bst_pkg::is_space(ch)) begin
			idle_mode = M_IDLE;
		end else if (ch == bst_pkg::CH_SLASH) begin
			idle_mode  = M_SLASH;
			idle_start = pos_q;
		end else if (bst_pkg::is_digit(ch)) begin
			idle_mode  = M_NUM;
			idle_start = pos_q;
		end else if (bst_pkg::is_ident_start(ch)) begin
			idle_mode  = M_IDENT;
			idle_start = pos_q;
			idle_kw    = bst_pkg::kw_advance(3'd0, ch);
		end else begin
			idle_emit = 1'b1;
			idle_mode = M_ERROR;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_q;
		start_d = start_q;
		kw_d    = kw_q;
		cnt     = 2'd0;
		r0      = bst_pkg::make_res(bst_pkg::TK_END, p16, p16);
		r1      = bst_pkg::make_res(bst_pkg::TK_END, p16, p16);
		if (kind) begin
			case (mode_q)
				M_NUM: begin
					r0  = bst_pkg::make_res(bst_pkg::TK_NAT, s16, p16);
					cnt = 2'd2;
				end
				M_IDENT: begin
					if (kw_q == bst_pkg::KW_LEN) begin
						r0  = bst_pkg::make_res(bst_pkg::TK_KW_SHOW, s16, p16);
						cnt = 2'd2;
					end else begin
						r0  = bst_pkg::make_res(bst_pkg::TK_UNKNOWN, s16, p16);
						cnt = 2'd1;
					end
				end
				M_SLASH: begin
					r0  = bst_pkg::make_res(bst_pkg::TK_ILLEGAL, s16, si16);
					cnt = 2'd1;
				end
				M_ERROR: cnt = 2'd0;
				default: cnt = 2'd1;
			endcase
			mode_d  = M_IDLE;
			pos_d   = '0;
			start_d = '0;
			kw_d    = 3'd0;
		end else if (mode_q == M_ERROR) begin
			mode_d = M_ERROR;
		end else if (&pos_q) begin
			r0     = bst_pkg::make_res(bst_pkg::TK_LONG, p16, p16);
			cnt    = 2'd1;
			mode_d = M_ERROR;
		end else begin
			pos_d = pos_inc;
			case (mode_q)
				M_NUM: begin
					if (!bst_pkg::is_digit(ch)) begin
						r0      = bst_pkg::make_res(bst_pkg::TK_NAT, s16, p16);
						r1      = idle_res;
						cnt     = idle_emit ? 2'd2 : 2'd1;
						mode_d  = idle_mode;
						start_d = idle_start;
						kw_d    = idle_kw;
					end
				end
				M_IDENT: begin
					if (bst_pkg::is_ident_start(ch) || bst_pkg::is_digit(ch)) begin
						kw_d = bst_pkg::kw_advance(kw_q, ch);
					end else if (kw_q == bst_pkg::KW_LEN) begin
						r0      = bst_pkg::make_res(bst_pkg::TK_KW_SHOW, s16, p16);
						r1      = idle_res;
						cnt     = idle_emit ? 2'd2 : 2'd1;
						mode_d  = idle_mode;
						start_d = idle_start;
						kw_d    = idle_kw;
					end else begin
						r0     = bst_pkg::make_res(bst_pkg::TK_UNKNOWN, s16, p16);
						cnt    = 2'd1;
						mode_d = M_ERROR;
					end
				end
				M_SLASH: begin
					if (ch == bst_pkg::CH_SLASH) begin
						mode_d = M_COMMENT;
					end else begin
						r0     = bst_pkg::make_res(bst_pkg::TK_ILLEGAL, s16, si16);
						cnt    = 2'd1;
						mode_d = M_ERROR;
					end
				end
				M_COMMENT: begin
					if (ch == bst_pkg::CH_NL)
						mode_d = M_IDLE;
				end
				default: begin
					r0      = idle_res;
					cnt     = idle_emit ? 2'd1 : 2'd0;
					mode_d  = idle_mode;
					start_d = idle_start;
					kw_d    = idle_kw;
				end
			endcase
		end
		r0.last = (cnt == 2'd1);
		r1.last = (cnt == 2'd2);
	end

	assign scan.cnt = step ? cnt : 2'd0;
	assign scan.r0  = r0;
	assign scan.r1  = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			kw_q    <= 3'd0;
		end else if (step) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			kw_q    <= kw_d;
		end
	end

endmodule

/* design/bst_res_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token result queue
// Small queue taking up to two results per cycle and giving one per beat.
// ----------------------------------------------------------------------------
module bst_res_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bst_pkg::scan_res_t                  push,
	input  logic                                pop,
	output bst_pkg::res_t                       head,
	output logic [bst_pkg::RES_CNT_W-1:0]       count
);

	localparam int PW = bst_pkg::RES_PTR_W;
	localparam int CW = bst_pkg::RES_CNT_W;

	bst_pkg::res_t   mem_q [bst_pkg::RES_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   wr_next;

	assign wr_next = wr_q + {{(PW-1){1'b0}}, 1'b1};
	assign head    = mem_q[rd_q];
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem_q[wr_q] <= push.r0;
		if (push.cnt == 2'd2)
			mem_q[wr_next] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PW'(push.cnt);
			rd_q    <= rd_q + PW'(pop);
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

endmodule

/* design/byte_stream_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream tokenizer
// Streaming lexer: source bytes in, natural/show tokens and errors out.
// ----------------------------------------------------------------------------
// src carries one beat per source byte (kind 0) and a closing beat (kind 1).
// res carries one token per beat with its byte span; last_of_item marks the
// final token caused by an input beat. A beat causes zero, one or two tokens.
// A beat taken on src is registered in the input stage; its tokens are written
// into the result queue, which drives res. Throughput: one beat per cycle while
// the queue has room; a beat giving two tokens is absorbed by the four-entry
// result queue. src.ready drops only while the queue holds over two tokens.
// The scanner holds its mode, byte position, token start and keyword match
// count; the closing beat returns them all to their reset values.
// Reset clears the lexer state, the input stage and the queue; no token is
// offered until a beat has been taken. A stalled res holds its head token
// and fills the queue; src then stalls with the pending beat held.
// ----------------------------------------------------------------------------
module byte_stream_tokenizer #(
	parameter int POS_WIDTH = bst_pkg::POS_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	bst_in_if.sink      src,
	bst_out_if.source   res
);

	localparam int CW = bst_pkg::RES_CNT_W;

	logic                 valid_s1;
	logic                 kind_s1;
	logic [7:0]           ch_s1;
	logic                 advance;
	logic                 pop;
	logic [CW-1:0]        fifo_count;
	bst_pkg::scan_res_t   scan;
	bst_pkg::res_t        head;

	assign advance   = valid_s1 && (fifo_count <= CW'(bst_pkg::RES_DEPTH - 2));
	assign src.ready = !valid_s1 || advance;
	assign pop       = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.valid && src.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			kind_s1 <= src.kind;
			ch_s1   <= src.ch;
		end
	end

	bst_scan #(
		.POS_WIDTH(POS_WIDTH)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.kind  (kind_s1),
		.ch    (ch_s1),
		.scan  (scan)
	);

	bst_res_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (scan),
		.pop   (pop),
		.head  (head),
		.count (fifo_count)
	);

	assign res.valid        = (fifo_count != '0);
	assign res.token_kind   = head.kind;
	assign res.span_start   = head.span_start;
	assign res.span_end     = head.span_end;
	assign res.last_of_item = head.last;

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(scan.cnt != 2'd0) |=> res.valid)
		else $error("pushed token not offered");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(scan.cnt == 2'd2) |-> (scan.r1.last && !scan.r0.last))
		else $error("token pair marked wrongly");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_count == '0) |-> src.ready)
		else $error("input stalled with empty queue");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_count > CW'(bst_pkg::RES_DEPTH - 2)) |-> (scan.cnt == 2'd0))
		else $error("push into full queue");

endmodule
